[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the GF(2^8) arithmetic unit.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/gfau_pkg.sv]
// Types, constants and field functions for the GF(2^8) arithmetic unit.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package gfau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_POW = 2'd2,
    OP_INV = 2'd3
  } op_t;

  localparam logic [7:0] GF_REDUCE  = 8'h1B;
  localparam logic [7:0] GF_ONE     = 8'h01;
  localparam logic [7:0] GF_INV_EXP = 8'd254;
  localparam int unsigned NUM_STEPS = 8;

  // One pipeline stage: running product, running square, exponent bits still
  // to use (LSB first), and the bypassed sum for additions.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] sq;
    logic [7:0] ex;
    logic [7:0] sum;
    logic       is_add;
  } stage_t;

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    logic [7:0] s;
    s = {v[6:0], 1'b0};
    if (v[7]) s = s ^ GF_REDUCE;
    return s;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = x;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc = acc ^ sh;
      sh = gf_double(sh);
    end
    return acc;
  endfunction

  // One square-and-multiply step.
  function automatic stage_t gf_step(input stage_t s);
    stage_t n;
    n        = s;
    n.acc    = s.ex[0] ? gf_mul(s.acc, s.sq) : s.acc;
    n.sq     = gf_mul(s.sq, s.sq);
    n.ex     = {1'b0, s.ex[7:1]};
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/gfau_if.sv]
// Valid/ready channel interfaces for the GF(2^8) arithmetic unit.
// Depends on gfau_pkg for the operation type.
`default_nettype none

interface gfau_req_if;
  logic            valid;
  logic            ready;
  gfau_pkg::op_t   operation;
  logic [7:0]      operand_a;
  logic [7:0]      operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface gfau_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

[rtl/gf256_arithmetic_unit.sv]
// GF(2^8) arithmetic unit (AES polynomial 0x11B): add, multiply, power, inverse.
// Depends on gfau_pkg, gfau_if.sv and assert_macros.svh.
//
// Usage:
//   req carries one item: operation, operand_a, operand_b. rsp returns one
//   result byte per item, in order. Both are valid/ready channels; a transfer
//   happens on a rising edge with valid and ready high.
//   An item is captured into an entry stage and then passes eight
//   square-and-multiply stages, one exponent bit per stage, and its result
//   is presented from the register of the last stage. Multiply runs the same
//   stages with exponent 1 and the second operand as the starting product;
//   inverse uses exponent 254; addition bypasses the products.
//   Throughput is one item per cycle while rsp does not stall; the depth is set
//   by the eight exponent bits, each a full field multiply plus a squaring.
//   When rsp stalls, each stage holds while the one after it is full and
//   empty stages still fill, so req.ready drops only once every stage holds
//   an item. req.ready follows rsp.ready combinationally in that case.
//   Reset (rst, synchronous) empties the pipeline; nothing else is cleared.
`default_nettype none

module gf256_arithmetic_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  gfau_req_if.sink   req,
  gfau_rsp_if.source rsp
);
  import gfau_pkg::*;

  localparam int unsigned LAST = NUM_STEPS;

  stage_t                 st  [LAST+1];
  logic   [LAST:0]        vld;
  logic   [LAST+1:0]      rdy;
  stage_t                 entry;

  // Map multiply, power and inverse onto acc * a^ex; addition uses the bypassed sum.
  always_comb begin
    entry.sq     = req.operand_a;
    entry.sum    = req.operand_a ^ req.operand_b;
    entry.is_add = (req.operation == OP_ADD);
    entry.acc    = GF_ONE;
    entry.ex     = '0;
    unique case (req.operation)
      OP_ADD: entry.ex = '0;
      OP_MUL: begin
        entry.acc = req.operand_b;
        entry.ex  = GF_ONE;
      end
      OP_POW: entry.ex = req.operand_b;
      OP_INV: entry.ex = GF_INV_EXP;
      default: entry.ex = '0;
    endcase
  end

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    rdy[LAST+1] = rsp.ready;
    for (int k = LAST; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= req.valid;
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) st[0] <= entry;
    for (int k = 1; k <= LAST; k++) begin
      if (rdy[k]) st[k] <= gf_step(st[k-1]);
    end
  end

  assign req.ready  = rdy[0];
  assign rsp.valid  = vld[LAST];
  assign rsp.result = st[LAST].is_add ? st[LAST].sum : st[LAST].acc;

  `include "assert_macros.svh"

  `ASSERT_CLK(a_exp_used_up, vld[LAST] |-> (st[LAST].ex == '0), "exponent bits left at output")
  `ASSERT_CLK(a_stall_only_full, !req.ready |-> (&vld && !rsp.ready), "input stalled with room")
  `ASSERT_CLK(a_held_stage, (vld[1] && !rdy[2]) |=> (vld[1] && $stable(st[1])), "stage 1 lost item")
  `ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> (vld == '0), "pipeline not empty after reset")

endmodule

`default_nettype wire

[tb/gfau_checker.sv]
// Result checker for the GF(2^8) arithmetic unit: watches both channels,
// predicts each result byte and compares it with what the unit returns.
// Depends on gfau_pkg for the operation type and field constants.
module gfau_checker
  import gfau_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  op_t        req_operation,
  input  logic [7:0] req_a,
  input  logic [7:0] req_b,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  logic [7:0] rsp_result,
  output int         faults,
  output int         outstanding,
  output int         checked
);

  typedef struct {
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] value;
  } gf_item_t;

  gf_item_t pending_results[$];

  // Multiply by x, folding the shifted-out bit back with the AES polynomial.
  function automatic logic [7:0] field_xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
  endfunction

  function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] term;
    acc  = 8'h00;
    term = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) acc ^= term;
      term = field_xtime(term);
    end
    return acc;
  endfunction

  // Left-to-right square-and-multiply; x^0 is one for any x, zero included.
  function automatic logic [7:0] field_power(input logic [7:0] base, input logic [7:0] ex);
    logic [7:0] acc;
    acc = GF_ONE;
    for (int k = 7; k >= 0; k--) begin
      acc = field_product(acc, acc);
      if (ex[k]) acc = field_product(acc, base);
    end
    return acc;
  endfunction

  function automatic logic [7:0] field_result(input op_t op, input logic [7:0] a,
                                              input logic [7:0] b);
    case (op)
      OP_ADD:  return a ^ b;
      OP_MUL:  return field_product(a, b);
      OP_POW:  return field_power(a, b);
      default: return (a == 8'h00) ? 8'h00 : field_power(a, GF_INV_EXP);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    faults++;
    if (faults <= 25) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  initial begin
    faults      = 0;
    outstanding = 0;
    checked     = 0;
  end

  always @(posedge clk) begin
    gf_item_t item;
    if (!rst) begin
      // push before pop: the queue front is always the oldest item
      if (req_valid && req_ready) begin
        item.op    = req_operation;
        item.a     = req_a;
        item.b     = req_b;
        item.value = field_result(req_operation, req_a, req_b);
        pending_results.push_back(item);
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %02h with no item outstanding", rsp_result));
        end else begin
          item = pending_results.pop_front();
          checked++;
          if (rsp_result !== item.value)
            report_mismatch($sformatf("%s a=%02h b=%02h: result %02h, wanted %02h",
                                      item.op.name(), item.a, item.b, rsp_result,
                                      item.value));
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

[tb/testbench.sv]
// Top of the GF(2^8) arithmetic unit testbench: clock, reset, stimulus,
// result back-pressure, watchdog and verdict.
// Depends on gfau_pkg, gfau_if.sv, gf256_arithmetic_unit and gfau_checker.
module testbench;
  import gfau_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;
  logic calm;
  int   faults;
  int   outstanding;
  int   checked;
  int   quiet_cycles;
  int   sent_per_op [4];

  gfau_req_if req ();
  gfau_rsp_if rsp ();

  gf256_arithmetic_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  gfau_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .req_a         (req.operand_a),
    .req_b         (req.operand_b),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_result    (rsp.result),
    .faults        (faults),
    .outstanding   (outstanding),
    .checked       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 18);
  endfunction

  // Mostly uniform bytes, with the edge values turning up now and then.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [4];
    corners = '{8'h00, 8'h01, 8'h80, 8'hFF};
    if ($urandom_range(7) == 0) return corners[$urandom_range(3)];
    return 8'($urandom);
  endfunction

  task automatic send_item(input op_t op, input logic [7:0] a, input logic [7:0] b);
    while (take_break()) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent_per_op[op]++;
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side: random stalls except during the calm stretch.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= !rst && !take_break();
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    op_t op;
    rst           = 1'b1;
    calm          = 1'b0;
    quiet_cycles  = 0;
    sent_per_op   = '{0, 0, 0, 0};
    req.valid     = 1'b0;
    req.operation = OP_ADD;
    req.operand_a = 8'h00;
    req.operand_b = 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_item(OP_ADD, 8'h00, 8'h00);
    send_item(OP_ADD, 8'hFF, 8'hFF);
    send_item(OP_ADD, 8'h55, 8'hAA);
    send_item(OP_MUL, 8'h00, 8'hFF);
    send_item(OP_MUL, 8'hFF, 8'hFF);
    send_item(OP_MUL, 8'h80, 8'h02);   // reduction on the top bit
    send_item(OP_MUL, 8'h57, 8'h83);
    send_item(OP_MUL, 8'h01, 8'hAA);
    send_item(OP_POW, 8'h00, 8'h00);   // zero to the zero is one
    send_item(OP_POW, 8'hFF, 8'h00);
    send_item(OP_POW, 8'h00, 8'h05);   // zero base gives zero
    send_item(OP_POW, 8'h00, 8'hFF);
    send_item(OP_POW, 8'hFF, 8'hFF);
    send_item(OP_POW, 8'h53, 8'h01);
    send_item(OP_POW, 8'h03, 8'hFE);
    send_item(OP_INV, 8'h00, 8'h00);   // inverse of zero is zero
    send_item(OP_INV, 8'h00, 8'hFF);
    send_item(OP_INV, 8'h01, 8'h5A);
    send_item(OP_INV, 8'h53, 8'hFF);   // operand_b ignored
    send_item(OP_INV, 8'hFF, 8'h00);
    send_item(OP_INV, 8'h80, 8'h80);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 600) && (n < 900);
      if (n == 1200) drain_results();
      op = op_t'($urandom_range(3));
      send_item(op, pick_byte(), pick_byte());
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: add %0d, multiply %0d, power %0d, inverse %0d.",
             sent_per_op[0] + sent_per_op[1] + sent_per_op[2] + sent_per_op[3],
             sent_per_op[0], sent_per_op[1], sent_per_op[2], sent_per_op[3]);
    $display("Compared %0d result bytes under random stalls on both channels.", checked);
    if (faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
